FILE: hdl/ddss_pkg.sv
// shared constants, command codes and types of the decimal digit scroller
// used by the converter and the top level; no dependencies
package ddss_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int VALUE_BITS = 32;

  // fixed port widths
  localparam int InDataW  = 32;
  localparam int CmdW     = 2;
  localparam int SegW     = 7;
  localparam int DigitW   = 4;
  localparam int OutDataW = 16;

  localparam int CntW = $clog2(MAX_DIGITS + 1);
  localparam int IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int BitW = $clog2(VALUE_BITS);
  localparam int BcdW = MAX_DIGITS * DigitW;

  localparam logic [CmdW-1:0] CMD_LOAD_TOTAL  = 2'd0;
  localparam logic [CmdW-1:0] CMD_LOAD_REGION = 2'd1;
  localparam logic [CmdW-1:0] CMD_SHOW_TOTAL  = 2'd2;
  localparam logic [CmdW-1:0] CMD_TICK        = 2'd3;

  // digit write stream from the converter to the digit stores
  typedef struct packed {
    logic              we;
    logic [IdxW-1:0]   addr;
    logic [DigitW-1:0] digit;
    logic              done;
    logic [CntW-1:0]   count;
  } ddss_wr_t;

  // active-low segments, bit 6 is a and bit 0 is g
  function automatic logic [SegW-1:0] seg_lut(input logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0:    s = 7'b0000001;
      4'd1:    s = 7'b1001111;
      4'd2:    s = 7'b0010010;
      4'd3:    s = 7'b0000110;
      4'd4:    s = 7'b1001100;
      4'd5:    s = 7'b0100100;
      4'd6:    s = 7'b0100000;
      4'd7:    s = 7'b0001111;
      4'd8:    s = 7'b0000000;
      4'd9:    s = 7'b0000100;
      default: s = 7'b0000001;
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/decimal_digit_scroller_seven_segment.sv
// top level of the decimal digit scroller: request handshake, digit stores,
// scroll index and segment output register; uses ddss_pkg and ddss_conv
//
//  channel  dir  tdata                          tuser
//  s_axis   in   value[31:0]                    command[1:0]
//  m_axis   out  segments[6:0], digit[10:7]     -
//
// a load shifts one bit per cycle through the shift-and-add-three register, then
// writes one digit per cycle into the digit store
// show and tick skip the converter; a tick result sits in the output register
// no request is taken while a load converts or while a result waits and is stalled
// reset clears both digit counts, the view and the scroll index; stores stay as is
module decimal_digit_scroller_seven_segment import ddss_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InDataW-1:0]   s_axis_tdata_i,   // value[31:0]
  input  logic [CmdW-1:0]      s_axis_tuser_i,   // command[1:0]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutDataW-1:0]  m_axis_tdata_o    // segments[6:0], digit[10:7], zeros
);

  logic              busy_q;
  logic              target_region_q;
  logic              region_view_q;
  logic [CntW-1:0]   total_cnt_q;
  logic [CntW-1:0]   region_cnt_q;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [DigitW-1:0] total_st_q  [MAX_DIGITS];
  logic [DigitW-1:0] region_st_q [MAX_DIGITS];
  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic              accept;
  logic              is_load;
  logic              is_tick;
  logic              start;
  ddss_wr_t          wr;

  logic [CntW-1:0]   act_cnt;
  logic [IdxW-1:0]   idx_eff;
  logic [IdxW-1:0]   pos;
  logic [DigitW-1:0] rd_digit;
  logic [DigitW-1:0] show_digit;
  logic              emit;

  assign s_axis_tready_o = !busy_q && (!out_valid_q || m_axis_tready_i);
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign is_load = (s_axis_tuser_i == CMD_LOAD_TOTAL) || (s_axis_tuser_i == CMD_LOAD_REGION);
  assign is_tick = (s_axis_tuser_i == CMD_TICK);
  assign start   = accept && is_load;

  ddss_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .value_i (s_axis_tdata_i),
    .wr_o    (wr)
  );

  // tick: wrap the shared index into the active count, most significant digit first
  always_comb begin
    act_cnt  = region_view_q ? region_cnt_q : total_cnt_q;
    idx_eff  = (CntW'(idx_q) >= act_cnt) ? '0 : idx_q;
    pos      = IdxW'(act_cnt - 1'b1 - CntW'(idx_eff));
    rd_digit = region_view_q ? region_st_q[pos] : total_st_q[pos];
    show_digit = (rd_digit > 4'd9) ? '0 : rd_digit;
    emit     = accept && is_tick && (act_cnt != '0);
    if (act_cnt == '0) begin
      idx_d = '0;
    end else if ((CntW'(idx_eff) + 1'b1) == act_cnt) begin
      idx_d = '0;
    end else begin
      idx_d = idx_eff + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q          <= 1'b0;
      target_region_q <= 1'b0;
      region_view_q   <= 1'b0;
      total_cnt_q     <= '0;
      region_cnt_q    <= '0;
      idx_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (start) begin
        busy_q          <= 1'b1;
        target_region_q <= (s_axis_tuser_i == CMD_LOAD_REGION);
      end else if (wr.done) begin
        busy_q <= 1'b0;
      end
      if (wr.done) begin
        if (target_region_q) begin
          region_cnt_q <= wr.count;
        end else begin
          total_cnt_q <= wr.count;
        end
      end
      if (accept && (s_axis_tuser_i == CMD_LOAD_REGION)) begin
        region_view_q <= 1'b1;
      end else if (accept && (s_axis_tuser_i == CMD_SHOW_TOTAL)) begin
        region_view_q <= 1'b0;
      end
      if (accept && is_tick) begin
        idx_q <= idx_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr.we) begin
      if (target_region_q) begin
        region_st_q[wr.addr] <= wr.digit;
      end else begin
        total_st_q[wr.addr] <= wr.digit;
      end
    end
    if (emit) begin
      out_data_q <= OutDataW'({show_digit, seg_lut(show_digit)});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

FILE: hdl/ddss_conv.sv
// bit-serial binary to decimal converter (shift and add three), then a digit scan
// that streams digits out least significant first with the digit count; uses ddss_pkg
module ddss_conv import ddss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [InDataW-1:0] value_i,
  output ddss_wr_t           wr_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic [BcdW-1:0]       adj;
  logic                  ovf_q, ovf_d;
  logic [BitW-1:0]       bit_cnt_q, bit_cnt_d;
  logic [CntW-1:0]       dig_cnt_q, dig_cnt_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       count_now;
  logic                  last_digit;

  // add three to every digit of five or more
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_q[i*DigitW +: DigitW] >= 4'd5) begin
        adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW] + 4'd3;
      end else begin
        adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW];
      end
    end
  end

  assign last_digit = (dig_cnt_q == CntW'(MAX_DIGITS - 1));
  assign count_now  = (bcd_q[DigitW-1:0] != '0) ? (dig_cnt_q + 1'b1) : count_q;

  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    ovf_d     = ovf_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    count_d   = count_q;
    wr_o      = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          bin_d     = VALUE_BITS'(value_i);
          bcd_d     = '0;
          ovf_d     = 1'b0;
          bit_cnt_d = '0;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        // a bit leaving the top digit means more digits than the store holds
        ovf_d     = ovf_q | adj[BcdW-1];
        bcd_d     = {adj[BcdW-2:0], bin_q[VALUE_BITS-1]};
        bin_d     = bin_q << 1;
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BitW'(VALUE_BITS - 1)) begin
          dig_cnt_d = '0;
          count_d   = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        wr_o.we    = 1'b1;
        wr_o.addr  = dig_cnt_q[IdxW-1:0];
        wr_o.digit = bcd_q[DigitW-1:0];
        bcd_d      = bcd_q >> DigitW;
        dig_cnt_d  = dig_cnt_q + 1'b1;
        count_d    = count_now;
        if (last_digit) begin
          wr_o.done  = 1'b1;
          wr_o.count = ovf_q ? CntW'(MAX_DIGITS) : count_now;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    ovf_q     <= ovf_d;
    bit_cnt_q <= bit_cnt_d;
    dig_cnt_q <= dig_cnt_d;
    count_q   <= count_d;
  end

endmodule
